@@ sv/bta_pkg.sv @@
// ============================================================================
// bta_pkg: shared types and constants of the buddy tree allocator
// Holds the node state codes, result status codes, register indexes and
// stream field widths.
// ============================================================================
package bta_pkg;

    typedef logic [1:0] node_t;

    localparam node_t NS_FREE  = 2'd0;
    localparam node_t NS_USED  = 2'd1;
    localparam node_t NS_SPLIT = 2'd2;
    localparam node_t NS_FULL  = 2'd3;

    typedef logic [1:0] status_t;

    localparam status_t STAT_DONE    = 2'd0;
    localparam status_t STAT_NOMEM   = 2'd1;
    localparam status_t STAT_IGNORED = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS    = 1'd1;

    localparam int LEVELS_CFG_W = 5;

    localparam int SIZE_W  = 32;
    localparam int ADDR_W  = 64;
    localparam int BYTES_W = 20;
    localparam int STAT_W  = 2;

    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 128;

    localparam logic CMD_ALLOC = 1'b0;

    function automatic logic is_taken(input node_t s);
        return (s == NS_USED) || (s == NS_FULL);
    endfunction

    // Parent state from the states of its two children.
    function automatic node_t merge_state(input node_t l, input node_t r);
        node_t ns;
        if ((l == NS_FREE) && (r == NS_FREE))
        begin
            ns = NS_FREE;
        end
        else if (is_taken(l) && is_taken(r))
        begin
            ns = NS_FULL;
        end
        else
        begin
            ns = NS_SPLIT;
        end
        return ns;
    endfunction

endpackage

@@ sv/bta_ram.sv @@
// ============================================================================
// bta_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module bta_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/bta_div.sv @@
// ============================================================================
// bta_div: divider by a constant, reciprocal multiply
// Multiplies by a scaled reciprocal of the divisor, then checks the remainder
// with a constant multiply; start runs through stg_reg into done_reg.
// ============================================================================
module bta_div #(
    parameter int DIVISOR = 16,
    parameter int NW      = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic          rem_zero
);

    localparam int LW = $clog2(DIVISOR);
    localparam int SH = NW + LW;
    localparam int MW = NW + 2;
    localparam int PW = NW + MW;
    // floor(2^SH / DIVISOR) + 1 is exact for every NW-bit dividend
    localparam logic [63:0]   RECIP64 = ((64'd1 << SH) / 64'(DIVISOR)) + 64'd1;
    localparam logic [MW-1:0] RECIP   = RECIP64[MW-1:0];

    logic [NW-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] q_reg, q_next;
    logic          rz_reg, rz_next;
    logic [1:0]    stg_reg, stg_next;
    logic          done_reg, done_next;
    logic [PW-1:0] prod;

    assign prod = PW'(dvd_reg) * PW'(RECIP);

    always_comb
    begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rz_next   = rz_reg;
        stg_next  = {stg_reg[0], start};
        done_next = stg_reg[1];
        if (start)
        begin
            dvd_next = dividend;
        end
        if (stg_reg[0])
        begin
            q_next = NW'(prod >> SH);
        end
        if (stg_reg[1])
        begin
            // remainder is zero when the quotient times the divisor gives it back
            rz_next = (dvd_reg == NW'(q_reg * NW'(DIVISOR)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            stg_reg  <= stg_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rz_reg  <= rz_next;
    end

    assign done     = done_reg;
    assign quot     = q_reg;
    assign rem_zero = rz_reg;

endmodule

@@ sv/buddy_tree_allocator_unit.sv @@
// ============================================================================
// buddy_tree_allocator_unit: binary buddy allocator over a node-state tree
// A small sequencer walks a 1-indexed tree of 2-bit node states kept in a
// single-port-pair RAM: left-first search for allocate, aligned lookup and
// buddy merge for free, then upward state propagation.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser: command; tdata: size, addr
//  m_      | out       | m_tvalid/m_tready  | tdata: status, addr, byte counts
//  cfg_    | in        | cfg_we (no wait)   | cfg_index, cfg_data
//
//  Order: one request at a time. Allocate first sizes the block (S_SIZE),
//  then searches the tree with one RAM read per node visited (S_A_RD,
//  S_A_EV), backtracks (S_A_BT), splits levels (S_A_WR), forms the
//  address (S_A_MUL, S_A_ADD) and propagates states upward (S_P_CHK,
//  S_P_L, S_P_R, S_P_P). Free divides, probes levels, merges buddies, then
//  propagates. The shared node RAM read port sets the pace.
//  Reset: a clearing pass writes every one of the 2^MAX_LEVELS nodes free,
//  one per cycle, and runs again after every REG_LEVELS write; s_tready
//  stays low during it.
//  Stalls: a finished beat waits in the output register while the next
//  request is accepted; the sequencer holds in its final state until the
//  output register is free.
// ============================================================================
module buddy_tree_allocator_unit #(
    parameter int MAX_LEVELS      = 16,
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tuser: command[0]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bta_pkg::IN_TUSER_W-1:0]   s_tuser,
    // tdata: request_size[31:0], block_address[95:32]
    input  logic [bta_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: status[1:0], result_address[65:2], used_bytes[85:66],
    //        free_bytes[105:86], total_bytes[125:106], zero fill[127:126]
    output logic [bta_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [bta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bta_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW    = MAX_LEVELS;
    localparam int DEPTH = 1 << MAX_LEVELS;
    localparam int LV_W  = $clog2(MAX_LEVELS + 1);
    localparam int MB_W  = $clog2(MIN_BLOCK_BYTES + 1);
    localparam int TOT_W = MB_W + MAX_LEVELS - 1;
    localparam int AD_W  = bta_pkg::ADDR_W;
    localparam int LEVELS_W_FIX = bta_pkg::LEVELS_CFG_W;

    // sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_SIZE  = 5'd2;
    localparam logic [4:0] S_A_RD  = 5'd3;
    localparam logic [4:0] S_A_EV  = 5'd4;
    localparam logic [4:0] S_A_BT  = 5'd5;
    localparam logic [4:0] S_A_WR  = 5'd6;
    localparam logic [4:0] S_A_MUL = 5'd7;
    localparam logic [4:0] S_A_ADD = 5'd8;
    localparam logic [4:0] S_F_CHK = 5'd9;
    localparam logic [4:0] S_F_DIV = 5'd10;
    localparam logic [4:0] S_F_RD  = 5'd11;
    localparam logic [4:0] S_F_EV  = 5'd12;
    localparam logic [4:0] S_M_CHK = 5'd13;
    localparam logic [4:0] S_M_EV  = 5'd14;
    localparam logic [4:0] S_P_CHK = 5'd15;
    localparam logic [4:0] S_P_L   = 5'd16;
    localparam logic [4:0] S_P_R   = 5'd17;
    localparam logic [4:0] S_P_P   = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    // control state
    logic [4:0]              state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [LV_W-1:0]         lvl_reg, lvl_next;
    logic [TOT_W-1:0]        alloc_reg, alloc_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // working registers
    logic [AD_W-1:0]         base_reg, base_next;
    logic [bta_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [AD_W-1:0]         baddr_reg, baddr_next;
    logic [AW-1:0]           n_reg, n_next;
    logic [LV_W-1:0]         dep_reg, dep_next;
    logic [LV_W-1:0]         goal_reg, goal_next;
    logic [LV_W-1:0]         k_reg, k_next;
    logic [TOT_W-1:0]        blk_reg, blk_next;
    logic [AW-1:0]           qsh_reg, qsh_next;
    bta_pkg::node_t          l_reg, l_next;
    bta_pkg::node_t          r_reg, r_next;
    logic [TOT_W-1:0]        prod_reg, prod_next;
    bta_pkg::status_t        stat_reg, stat_next;
    logic [AD_W-1:0]         raddr_reg, raddr_next;
    logic [bta_pkg::OUT_TDATA_W-1:0] out_reg, out_next;

    // node RAM
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    bta_pkg::node_t          wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    bta_pkg::node_t          rd_data;

    // divider
    logic                    div_start;
    logic [TOT_W-1:0]        div_dvd;
    logic                    div_done;
    logic [TOT_W-1:0]        div_quot;
    logic                    div_rz;

    logic [TOT_W-1:0]        total;
    logic [AD_W-1:0]         off_full;
    logic [AW-1:0]           jk;
    logic [AW-1:0]           f_idx;
    logic [LEVELS_W_FIX-1:0] lv_cfg;
    logic [AD_W-1:0]         used_w, free_w, total_w;

    bta_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bta_div #(
        .DIVISOR (MIN_BLOCK_BYTES),
        .NW      (TOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .done     (div_done),
        .quot     (div_quot),
        .rem_zero (div_rz)
    );

    // heap size: MIN_BLOCK_BYTES << (levels - 1), zero when uninitialized
    assign total = (lvl_reg == '0) ? '0
                 : (TOT_W'(MIN_BLOCK_BYTES) << (lvl_reg - 1'b1));

    assign off_full = baddr_reg - base_reg;
    assign div_dvd  = off_full[TOT_W-1:0];

    // block index within its level, scaled to min-block units
    assign jk    = (n_reg - (AW'(1) << goal_reg)) << k_reg;
    assign f_idx = (AW'(1) << dep_reg) | qsh_reg;

    assign lv_cfg = cfg_data[LEVELS_W_FIX-1:0];

    assign used_w  = AD_W'(alloc_reg);
    assign free_w  = AD_W'(total - alloc_reg);
    assign total_w = AD_W'(total);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        lvl_next      = lvl_reg;
        alloc_next    = alloc_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        base_next     = base_reg;
        size_next     = size_reg;
        baddr_next    = baddr_reg;
        n_next        = n_reg;
        dep_next      = dep_reg;
        goal_next     = goal_reg;
        k_next        = k_reg;
        blk_next      = blk_reg;
        qsh_next      = qsh_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        prod_next     = prod_reg;
        stat_next     = stat_reg;
        raddr_next    = raddr_reg;
        out_next      = out_reg;
        wr_en         = 1'b0;
        wr_addr       = n_reg;
        wr_data       = bta_pkg::NS_FREE;
        rd_en         = 1'b0;
        rd_addr       = n_reg;
        div_start     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep every node back to free
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = bta_pkg::NS_FREE;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    size_next  = s_tdata[bta_pkg::SIZE_W-1:0];
                    baddr_next = s_tdata[bta_pkg::SIZE_W +: AD_W];
                    stat_next  = bta_pkg::STAT_DONE;
                    raddr_next = '0;
                    if (s_tuser[0] == bta_pkg::CMD_ALLOC)
                    begin
                        if ((s_tdata[bta_pkg::SIZE_W-1:0] == '0) || (lvl_reg == '0))
                        begin
                            stat_next  = bta_pkg::STAT_NOMEM;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            goal_next  = lvl_reg - 1'b1;
                            k_next     = '0;
                            blk_next   = TOT_W'(MIN_BLOCK_BYTES);
                            state_next = S_SIZE;
                        end
                    end
                    else
                    begin
                        state_next = S_F_CHK;
                    end
                end
            end
            S_SIZE:
            begin
                // double the block until it covers the request, else report no memory
                if (AD_W'(blk_reg) >= AD_W'(size_reg))
                begin
                    n_next     = AW'(1);
                    dep_next   = '0;
                    state_next = S_A_RD;
                end
                else if (goal_reg == '0)
                begin
                    stat_next  = bta_pkg::STAT_NOMEM;
                    state_next = S_DONE;
                end
                else
                begin
                    goal_next = goal_reg - 1'b1;
                    k_next    = k_reg + 1'b1;
                    blk_next  = {blk_reg[TOT_W-2:0], 1'b0};
                end
            end
            S_A_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = n_reg;
                state_next = S_A_EV;
            end
            S_A_EV:
            begin
                if (bta_pkg::is_taken(rd_data))
                begin
                    state_next = S_A_BT;
                end
                else if (rd_data == bta_pkg::NS_FREE)
                begin
                    // everything below a free node is free: take leftmost path
                    state_next = S_A_WR;
                end
                else if (dep_reg == goal_reg)
                begin
                    state_next = S_A_BT;
                end
                else
                begin
                    n_next     = n_reg << 1;
                    dep_next   = dep_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_A_BT:
            begin
                // climb past right children, then step to the right sibling; no memory at the root
                if (n_reg == AW'(1))
                begin
                    stat_next  = bta_pkg::STAT_NOMEM;
                    state_next = S_DONE;
                end
                else if (n_reg[0])
                begin
                    n_next   = n_reg >> 1;
                    dep_next = dep_reg - 1'b1;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_A_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = n_reg;
                if (dep_reg == goal_reg)
                begin
                    wr_data    = bta_pkg::NS_USED;
                    alloc_next = alloc_reg + blk_reg;
                    state_next = S_A_MUL;
                end
                else
                begin
                    wr_data  = bta_pkg::NS_SPLIT;
                    n_next   = n_reg << 1;
                    dep_next = dep_reg + 1'b1;
                end
            end
            S_A_MUL:
            begin
                prod_next  = TOT_W'(TOT_W'(jk) * TOT_W'(MIN_BLOCK_BYTES));
                state_next = S_A_ADD;
            end
            S_A_ADD:
            begin
                raddr_next = base_reg + AD_W'(prod_reg);
                state_next = S_P_CHK;
            end
            S_F_CHK:
            begin
                if ((lvl_reg == '0) || (baddr_reg < base_reg) || (off_full >= total_w))
                begin
                    stat_next  = bta_pkg::STAT_IGNORED;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_F_DIV;
                end
            end
            S_F_DIV:
            begin
                if (div_done)
                begin
                    if (!div_rz)
                    begin
                        stat_next  = bta_pkg::STAT_IGNORED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        qsh_next   = div_quot[AW-1:0];
                        dep_next   = lvl_reg - 1'b1;
                        blk_next   = TOT_W'(MIN_BLOCK_BYTES);
                        state_next = S_F_RD;
                    end
                end
            end
            S_F_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = f_idx;
                n_next     = f_idx;
                state_next = S_F_EV;
            end
            S_F_EV:
            begin
                if (rd_data == bta_pkg::NS_USED)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = n_reg;
                    wr_data    = bta_pkg::NS_FREE;
                    alloc_next = alloc_reg - blk_reg;
                    state_next = S_M_CHK;
                end
                else if ((dep_reg == '0) || qsh_reg[0])
                begin
                    // no larger block starts at this offset
                    stat_next  = bta_pkg::STAT_IGNORED;
                    state_next = S_DONE;
                end
                else
                begin
                    qsh_next   = qsh_reg >> 1;
                    dep_next   = dep_reg - 1'b1;
                    blk_next   = {blk_reg[TOT_W-2:0], 1'b0};
                    state_next = S_F_RD;
                end
            end
            S_M_CHK:
            begin
                if (n_reg == AW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = n_reg ^ AW'(1);
                    state_next = S_M_EV;
                end
            end
            S_M_EV:
            begin
                if (rd_data != bta_pkg::NS_FREE)
                begin
                    state_next = S_P_CHK;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = n_reg >> 1;
                    wr_data    = bta_pkg::NS_FREE;
                    n_next     = n_reg >> 1;
                    state_next = S_M_CHK;
                end
            end
            S_P_CHK:
            begin
                if (n_reg <= AW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {n_reg[AW-1:1], 1'b0};
                    state_next = S_P_L;
                end
            end
            S_P_L:
            begin
                l_next     = rd_data;
                rd_en      = 1'b1;
                rd_addr    = {n_reg[AW-1:1], 1'b1};
                state_next = S_P_R;
            end
            S_P_R:
            begin
                r_next     = rd_data;
                rd_en      = 1'b1;
                rd_addr    = n_reg >> 1;
                state_next = S_P_P;
            end
            S_P_P:
            begin
                // stop as soon as the parent already holds the merged state
                if (rd_data == bta_pkg::merge_state(l_reg, r_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = n_reg >> 1;
                    wr_data    = bta_pkg::merge_state(l_reg, r_reg);
                    n_next     = n_reg >> 1;
                    state_next = S_P_CHK;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next = {2'b00,
                                total_w[bta_pkg::BYTES_W-1:0],
                                free_w[bta_pkg::BYTES_W-1:0],
                                used_w[bta_pkg::BYTES_W-1:0],
                                raddr_reg,
                                stat_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            unique case (cfg_index)
                bta_pkg::REG_HEAP_BASE:
                begin
                    base_next = cfg_data;
                end
                bta_pkg::REG_LEVELS:
                begin
                    if (lv_cfg > LEVELS_W_FIX'(MAX_LEVELS))
                    begin
                        lvl_next = LV_W'(MAX_LEVELS);
                    end
                    else
                    begin
                        lvl_next = LV_W'(lv_cfg);
                    end
                    alloc_next = '0;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            lvl_reg      <= '0;
            alloc_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            base_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            lvl_reg      <= lvl_next;
            alloc_reg    <= alloc_next;
            m_tvalid_reg <= m_tvalid_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        baddr_reg <= baddr_next;
        n_reg     <= n_next;
        dep_reg   <= dep_next;
        goal_reg  <= goal_next;
        k_reg     <= k_next;
        blk_reg   <= blk_next;
        qsh_reg   <= qsh_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        prod_reg  <= prod_next;
        stat_reg  <= stat_next;
        raddr_reg <= raddr_next;
        out_reg   <= out_next;
    end

endmodule

@@ tb/sv/buddy_tree_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// buddy_tree_allocator_unit_tb: self-checking bench for the buddy allocator
// Drives allocate and free beats through the input stream and keeps its own
// copy of the node-state tree to predict every output beat. It covers the
// uninitialized heap, size rounding and limits, exhaustion, bad frees, merges,
// the level clamp, address wrap, and random traffic under changing back
// pressure.
// ============================================================================
module buddy_tree_allocator_unit_tb;

    localparam int  MAX_LEV    = 16;
    localparam int  MIN_BLK    = 16;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct {
        bta_pkg::status_t status;
        logic [63:0] addr;
        logic [19:0] used;
        logic [19:0] avail;
        logic [19:0] total;
    } alloc_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [bta_pkg::IN_TUSER_W-1:0]   s_tuser;
    logic [bta_pkg::IN_TDATA_W-1:0]   s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [bta_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                             cfg_we;
    logic [bta_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [bta_pkg::CFG_DATA_W-1:0]   cfg_data;

    // Shadow copy of the allocator state
    bta_pkg::node_t  tree [0:(1<<MAX_LEV)-1];
    logic [63:0]     base_addr;
    int              levels;
    longint unsigned held_bytes;

    alloc_result_t   pending_results[$];
    logic [63:0]     live_blocks[$];
    int              send_idle_pct;
    int              recv_idle_pct;
    int              mismatches;
    int              beats_checked;
    int              allocs_sent;
    int              frees_sent;

    buddy_tree_allocator_unit #(
        .MAX_LEVELS      (MAX_LEV),
        .MIN_BLOCK_BYTES (MIN_BLK)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] heap_bytes();
        if (levels == 0)
        begin
            return 64'd0;
        end
        return 64'(MIN_BLK) << (levels - 1);
    endfunction

    function automatic void wipe_tree();
        for (int i = 0; i < (1 << MAX_LEV); i++)
        begin
            tree[i] = bta_pkg::NS_FREE;
        end
        held_bytes = 0;
    endfunction

    function automatic bit taken(input bta_pkg::node_t s);
        return (s == bta_pkg::NS_USED) || (s == bta_pkg::NS_FULL);
    endfunction

    // Walk toward the root, recomputing each parent until nothing changes.
    function automatic void settle_up(input int unsigned n);
        int unsigned    p;
        bta_pkg::node_t ns;
        while (n > 1)
        begin
            p = n >> 1;
            if (tree[2*p] == bta_pkg::NS_FREE && tree[2*p+1] == bta_pkg::NS_FREE)
            begin
                ns = bta_pkg::NS_FREE;
            end
            else if (taken(tree[2*p]) && taken(tree[2*p+1]))
            begin
                ns = bta_pkg::NS_FULL;
            end
            else
            begin
                ns = bta_pkg::NS_SPLIT;
            end
            if (tree[p] == ns)
            begin
                break;
            end
            tree[p] = ns;
            n = p;
        end
    endfunction

    // Left-first search; splits on the way down and undoes a fruitless split.
    function automatic int unsigned find_free_node(input int unsigned n, input int depth,
                                                   input int goal);
        bta_pkg::node_t s;
        bit             opened;
        int unsigned    hit;
        s = tree[n];
        opened = 1'b0;
        if (taken(s))
        begin
            return 0;
        end
        if (depth == goal)
        begin
            return (s == bta_pkg::NS_FREE) ? n : 0;
        end
        if (s == bta_pkg::NS_FREE)
        begin
            tree[n] = bta_pkg::NS_SPLIT;
            tree[2*n] = bta_pkg::NS_FREE;
            tree[2*n+1] = bta_pkg::NS_FREE;
            opened = 1'b1;
        end
        hit = find_free_node(2*n, depth + 1, goal);
        if (hit == 0)
        begin
            hit = find_free_node(2*n + 1, depth + 1, goal);
        end
        if (hit == 0 && opened)
        begin
            tree[n] = bta_pkg::NS_FREE;
        end
        return hit;
    endfunction

    function automatic bta_pkg::status_t model_alloc(input logic [31:0] size,
                                                     output logic [63:0] addr);
        logic [63:0] blk;
        int          goal;
        int unsigned n;
        addr = 64'd0;
        if (size == 0 || levels == 0)
        begin
            return bta_pkg::STAT_NOMEM;
        end
        blk = MIN_BLK;
        goal = levels - 1;
        while (blk < size)
        begin
            if (goal == 0)
            begin
                return bta_pkg::STAT_NOMEM;
            end
            goal--;
            blk = blk << 1;
        end
        n = find_free_node(1, 0, goal);
        if (n == 0)
        begin
            return bta_pkg::STAT_NOMEM;
        end
        tree[n] = bta_pkg::NS_USED;
        held_bytes += blk;
        settle_up(n);
        addr = base_addr + 64'(n - (1 << goal)) * (heap_bytes() >> goal);
        return bta_pkg::STAT_DONE;
    endfunction

    function automatic bta_pkg::status_t model_free(input logic [63:0] a);
        logic [63:0] off;
        logic [63:0] bsz;
        int unsigned hit;
        int unsigned n;
        int          hit_lev;
        if (levels == 0 || a < base_addr)
        begin
            return bta_pkg::STAT_IGNORED;
        end
        off = a - base_addr;
        if (off >= heap_bytes())
        begin
            return bta_pkg::STAT_IGNORED;
        end
        hit = 0;
        hit_lev = 0;
        // Smallest block size first
        for (int lv = levels - 1; lv >= 0; lv--)
        begin
            bsz = heap_bytes() >> lv;
            if (bsz != 0 && (off % bsz) == 0)
            begin
                n = (1 << lv) + int'(off / bsz);
                if (tree[n] == bta_pkg::NS_USED)
                begin
                    hit = n;
                    hit_lev = lv;
                    break;
                end
            end
        end
        if (hit == 0)
        begin
            return bta_pkg::STAT_IGNORED;
        end
        tree[hit] = bta_pkg::NS_FREE;
        held_bytes -= heap_bytes() >> hit_lev;
        n = hit;
        while (n > 1)
        begin
            if (tree[n ^ 1] != bta_pkg::NS_FREE)
            begin
                break;
            end
            tree[n >> 1] = bta_pkg::NS_FREE;
            n = n >> 1;
        end
        if (n > 1)
        begin
            settle_up(n);
        end
        return bta_pkg::STAT_DONE;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Send one beat, idle first at the current rate, and log its prediction
    // once the handshake completes. Valid is left high; the caller drops it.
    task automatic send_request(input logic cmd, input logic [31:0] size,
                                input logic [63:0] addr);
        alloc_result_t r;
        logic [63:0]   got_addr;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {addr, size};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);

        got_addr = 64'd0;
        if (cmd == bta_pkg::CMD_ALLOC)
        begin
            r.status = model_alloc(size, got_addr);
            if (r.status == bta_pkg::STAT_DONE)
            begin
                live_blocks.push_back(got_addr);
            end
            allocs_sent++;
        end
        else
        begin
            r.status = model_free(addr);
            if (r.status == bta_pkg::STAT_DONE)
            begin
                for (int i = live_blocks.size() - 1; i >= 0; i--)
                begin
                    if (live_blocks[i] == addr)
                    begin
                        live_blocks.delete(i);
                    end
                end
            end
            frees_sent++;
        end
        r.addr  = got_addr;
        r.used  = held_bytes[19:0];
        r.avail = 20'(heap_bytes() - held_bytes);
        r.total = 20'(heap_bytes());
        pending_results.push_back(r);
    endtask

    task automatic alloc_beat(input logic [31:0] size);
        send_request(bta_pkg::CMD_ALLOC, size, 64'($urandom()));
    endtask

    task automatic free_beat(input logic [63:0] addr);
        send_request(CMD_FREE, $urandom(), addr);
    endtask

    // Drop valid and hold until every predicted beat has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bta_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        logic [4:0] lv;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == bta_pkg::REG_HEAP_BASE)
        begin
            base_addr = val;
        end
        else
        begin
            lv = val[4:0];
            levels = (lv > MAX_LEV) ? MAX_LEV : int'(lv);
            wipe_tree();
            live_blocks.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Output checker and receiver back pressure
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected output beat tdata=%h", m_tdata);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status || m_tdata[65:2] !== want.addr ||
                    m_tdata[85:66] !== want.used || m_tdata[105:86] !== want.avail ||
                    m_tdata[125:106] !== want.total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: beat %0d exp st=%0d addr=%h used=%0d free=%0d tot=%0d",
                                 beats_checked, want.status, want.addr, want.used,
                                 want.avail, want.total);
                        $display("       got st=%0d addr=%h used=%0d free=%0d tot=%0d",
                                 m_tdata[1:0], m_tdata[65:2], m_tdata[85:66],
                                 m_tdata[105:86], m_tdata[125:106]);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Uninitialized heap rejects everything, before and after an explicit zero.
    task automatic test_uninitialized();
        alloc_beat(32'd16);
        free_beat(64'd0);
        drain();
        write_reg(bta_pkg::REG_LEVELS, 64'd0);
        alloc_beat(32'd1);
        free_beat(64'd16);
        drain();
    endtask

    // Small heap: rounding, limits, exhaustion, bad frees and merging.
    task automatic test_small_heap();
        write_reg(bta_pkg::REG_HEAP_BASE, 64'h0000_0000_0001_0000);
        write_reg(bta_pkg::REG_LEVELS, 64'd4);    // 128 bytes
        alloc_beat(32'd0);                        // zero request
        alloc_beat(32'd129);                      // larger than heap
        alloc_beat(32'hFFFF_FFFF);
        alloc_beat(32'd1);                        // rounds to 16 -> offset 0
        alloc_beat(32'd17);                       // rounds to 32 -> offset 32
        alloc_beat(32'd16);                       // offset 16
        alloc_beat(32'd64);                       // right half
        alloc_beat(32'd16);                       // no room left
        free_beat(64'h0000_0000_0000_FFFF);       // below base
        free_beat(64'h0000_0000_0001_0080);       // past the end
        free_beat(64'h0000_0000_0001_0008);       // not a block start
        free_beat(64'h0001_0000_0000_0000);       // high address bits set
        free_beat(64'h0000_0000_0001_0010);       // frees and merges nothing
        free_beat(64'h0000_0000_0001_0010);       // double free
        free_beat(64'h0000_0000_0001_0000);       // merges with buddy
        free_beat(64'h0000_0000_0001_0020);
        free_beat(64'h0000_0000_0001_0040);       // whole tree free again
        alloc_beat(32'd128);                      // whole heap
        alloc_beat(32'd16);
        free_beat(64'h0000_0000_0001_0000);
        drain();
    endtask

    // Level register above the maximum is clamped; byte counts reach the full 524288-byte heap.
    task automatic test_level_clamp();
        write_reg(bta_pkg::REG_HEAP_BASE, 64'd0);
        write_reg(bta_pkg::REG_LEVELS, 64'd31);
        alloc_beat(32'd524288);
        alloc_beat(32'd16);
        free_beat(64'd0);
        alloc_beat(32'd524289);
        alloc_beat(32'd16);
        alloc_beat(32'd16);
        alloc_beat(32'd262144);
        free_beat(64'd16);
        free_beat(64'd0);
        free_beat(64'd262144);
        drain();
    endtask

    // Block address wraps past the top of the 64-bit space; one-level heap.
    task automatic test_address_wrap();
        write_reg(bta_pkg::REG_HEAP_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
        write_reg(bta_pkg::REG_LEVELS, 64'd3);
        alloc_beat(32'd16);
        alloc_beat(32'd16);
        free_beat(64'd0);
        free_beat(64'hFFFF_FFFF_FFFF_FFF0);
        drain();
        write_reg(bta_pkg::REG_LEVELS, 64'd1);    // 16-byte heap
        alloc_beat(32'd17);
        alloc_beat(32'd16);
        alloc_beat(32'd1);
        drain();
    endtask

    // Random traffic: mostly allocs and frees of live blocks, plus noise.
    task automatic test_random_traffic(input int count, input int lev);
        int          pick;
        int          idx;
        logic [31:0] sz;
        write_reg(bta_pkg::REG_HEAP_BASE, {$urandom(), $urandom()});
        write_reg(bta_pkg::REG_LEVELS, 64'(lev));
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                if ($urandom_range(19) == 0)
                begin
                    sz = $urandom();
                end
                else
                begin
                    sz = $urandom_range(1, MIN_BLK << $urandom_range(0, levels - 1));
                end
                alloc_beat(sz);
            end
            else if (pick < 90 && live_blocks.size() != 0)
            begin
                idx = $urandom_range(live_blocks.size() - 1);
                free_beat(live_blocks[idx]);
            end
            else if (pick < 95)
            begin
                free_beat(base_addr + 64'($urandom_range(0, int'(heap_bytes()) - 1)));
            end
            else
            begin
                free_beat({$urandom(), $urandom()});
            end
            // Let the pipeline run dry once, halfway through
            if (i == count / 2)
            begin
                drain();
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = '0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        beats_checked = 0;
        allocs_sent   = 0;
        frees_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        base_addr     = 64'd0;
        levels        = 0;
        wipe_tree();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 49;
        test_uninitialized();
        test_small_heap();
        test_level_clamp();
        test_address_wrap();
        test_random_traffic(190, 6);

        send_idle_pct = 49;
        recv_idle_pct = 20;
        test_random_traffic(190, 4);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(190, 8);

        repeat (50) @(posedge clk);
        $display("Covered %0d allocate and %0d free beats, %0d output beats checked,",
                 allocs_sent, frees_sent, beats_checked);
        $display("over empty, small, clamped, wrapping and randomly loaded heaps.");
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("%0d mismatches, %0d beats missing", mismatches, pending_results.size());
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("Timeout with %0d beats outstanding", pending_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule

@@ buddy_tree_allocator_unit.f @@
sv/bta_pkg.sv
sv/bta_ram.sv
sv/bta_div.sv
sv/buddy_tree_allocator_unit.sv
tb/sv/buddy_tree_allocator_unit_tb.sv
